FILE: rtl/wsm_pkg.sv
// Package for the wheel speed mixer: shared constants, widths and the
// sequencer state type. No dependencies.
package wsm_pkg;

  // Default parameter values
  localparam int INPUT_WIDTH_DEF     = 16;
  localparam int SCALE_FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int LIMIT_W = 15;
  localparam int SPEED_W = 16;

  // Fixed-point constants, Q0.16
  localparam logic [15:0] HALF_ROOT2_Q16 = 16'd46341;
  localparam logic [15:0] SHRINK_Q16     = 16'd64225;
  localparam logic [15:0] ROUND_UP_Q16   = 16'd65535;
  localparam int          Q16_SHIFT      = 16;

  // Speed limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd8191;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_KO_MUL,
    S_KO,
    S_SQA,
    S_SQB,
    S_ROOT_GO,
    S_ROOT,
    S_CHK_MUL,
    S_CHK,
    S_SHRINK_MUL,
    S_SHRINK,
    S_OUT
  } wsm_state_t;

endpackage

FILE: rtl/wheel_speed_mixer_with_scaling.sv
// Top level of the swerve wheel speed mixer: sequencer, scale state and ports.
// Depends on wsm_pkg, wsm_mul and wsm_isqrt.

// Takes one chassis command (vel_x, vel_y, rot_rate, drive_enable, reverse
// bits), forms four wheel magnitudes as floor square roots of the summed
// squared components, shrinks the persistent Q1.SCALE_FRAC_BITS scale by
// about 0.98 per step until no scaled magnitude exceeds speed_limit, and
// returns the four signed wheel speeds. One command is in work at a time;
// s_axis_tready is high only while idle. The time a command takes is set
// by the one shared multiplier that serves every product, by the square
// root unit that yields one bit per cycle and by the number of shrink
// steps. A finished result waits in the output register and the next
// command is taken meanwhile. The user must write speed_limit through
// cfg_wen/cfg_wdata only while the block is idle; the block itself does
// not enforce this.
module wheel_speed_mixer_with_scaling
  import wsm_pkg::*;
#(
  parameter int INPUT_WIDTH     = INPUT_WIDTH_DEF,
  parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration: speed_limit
  input  logic                                 cfg_wen,
  input  logic [LIMIT_W-1:0]                   cfg_wdata,
  // Command request; tdata from bit 0: vel_x, vel_y, rot_rate, zero fill
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((3*INPUT_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // tuser from bit 0: drive_enable, reverse_0, reverse_1, reverse_2, reverse_3
  input  logic [4:0]                           s_axis_tuser,
  // Result request; tdata from bit 0: speed_0, speed_1, speed_2, speed_3
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [4*SPEED_W-1:0]                 m_axis_tdata
);

  localparam int W   = INPUT_WIDTH;
  localparam int F   = SCALE_FRAC_BITS;
  localparam int MWA = (W + 1 > F + 1) ? W + 1 : F + 1;
  localparam int MW  = (MWA > 16) ? MWA : 16;
  localparam int PW  = 2 * MW;
  localparam int RW  = 2 * W + 2;
  localparam int QW  = W + 1;

  wsm_state_t state, state_next;

  // Registers
  logic [LIMIT_W-1:0]    speed_limit;
  logic [F:0]            speed_scale;
  logic signed [W-1:0]   vx, vy, om;
  logic                  enable;
  logic [3:0]            rev;
  logic signed [W:0]     ko;
  logic [1:0]            wheel;
  logic [RW-1:0]         sq_a;
  logic [QW-1:0]         mag [4];
  logic [SPEED_W-1:0]    sc  [4];

  // Shared units
  logic                  mul_en;
  logic [MW-1:0]         mul_a, mul_b;
  logic [PW-1:0]         prod;
  logic                  root_start;
  logic                  root_done;
  logic [QW-1:0]         root;

  logic                  in_req;
  logic                  out_req;

  // Combinational helpers
  logic [W-1:0]          om_abs;
  logic [PW:0]           ko_sum;
  logic [W:0]            ko_mag;
  logic signed [W:0]     ko_calc;
  logic signed [W+1:0]   op_a, op_b;
  logic [QW-1:0]         abs_a, abs_b;
  logic [PW-1:0]         chk;
  logic                  over;
  logic [SPEED_W-1:0]    spd [4];

  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign out_req       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  wsm_mul #(.AW(MW), .BW(MW)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  wsm_isqrt #(.RW(RW)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (RW'(sq_a + RW'(prod))),
    .done     (root_done),
    .root     (root)
  );

  // Rotation term: floor of K times rot_rate
  always_comb begin
    om_abs  = om[W-1] ? W'(~om + 1'b1) : W'(om);
    ko_sum  = {1'b0, prod} + (om[W-1] ? (PW+1)'(ROUND_UP_Q16) : '0);
    ko_mag  = (W+1)'(ko_sum >> Q16_SHIFT);
    ko_calc = om[W-1] ? -$signed(ko_mag) : $signed(ko_mag);
  end

  // Wheel operands: y term minus K*omega on wheels 0 and 3, x term on 0 and 1
  always_comb begin
    if (wheel == 2'd0 || wheel == 2'd3) begin
      op_a = $signed({{2{vy[W-1]}}, vy}) - $signed({ko[W], ko});
    end else begin
      op_a = $signed({{2{vy[W-1]}}, vy}) + $signed({ko[W], ko});
    end
    if (wheel == 2'd0 || wheel == 2'd1) begin
      op_b = $signed({{2{vx[W-1]}}, vx}) - $signed({ko[W], ko});
    end else begin
      op_b = $signed({{2{vx[W-1]}}, vx}) + $signed({ko[W], ko});
    end
    abs_a = op_a[W+1] ? QW'(-op_a) : QW'(op_a);
    abs_b = op_b[W+1] ? QW'(-op_b) : QW'(op_b);
  end

  // Scaled magnitude and limit compare
  always_comb begin
    chk  = prod >> F;
    over = chk > PW'(speed_limit);
  end

  // Final speeds: gate by enable, negate per reverse bit
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      spd[i] = enable ? sc[i] : '0;
      if (rev[i]) begin
        spd[i] = SPEED_W'(~spd[i] + 1'b1);
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit controls
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    root_start = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_req) begin
          state_next = S_KO_MUL;
        end
      end
      S_KO_MUL: begin
        mul_en     = 1'b1;
        mul_a      = MW'(om_abs);
        mul_b      = MW'(HALF_ROOT2_Q16);
        state_next = S_KO;
      end
      S_KO: begin
        state_next = S_SQA;
      end
      S_SQA: begin
        mul_en     = 1'b1;
        mul_a      = MW'(abs_a);
        mul_b      = MW'(abs_a);
        state_next = S_SQB;
      end
      S_SQB: begin
        mul_en     = 1'b1;
        mul_a      = MW'(abs_b);
        mul_b      = MW'(abs_b);
        state_next = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        root_start = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          state_next = (wheel == 2'd3) ? S_CHK_MUL : S_SQA;
        end
      end
      S_CHK_MUL: begin
        mul_en     = 1'b1;
        mul_a      = MW'(mag[wheel]);
        mul_b      = MW'(speed_scale);
        state_next = S_CHK;
      end
      S_CHK: begin
        if (over) begin
          state_next = S_SHRINK_MUL;
        end else if (wheel == 2'd3) begin
          state_next = S_OUT;
        end else begin
          state_next = S_CHK_MUL;
        end
      end
      S_SHRINK_MUL: begin
        mul_en     = 1'b1;
        mul_a      = MW'(speed_scale);
        mul_b      = MW'(SHRINK_Q16);
        state_next = S_SHRINK;
      end
      S_SHRINK: begin
        state_next = S_CHK_MUL;
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Persistent state: limit register and scale
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= LIMIT_RESET;
      speed_scale <= (F+1)'(1) << F;
    end else begin
      if (cfg_wen) begin
        speed_limit <= cfg_wdata;
      end
      if (state == S_SHRINK) begin
        speed_scale <= (F+1)'(prod >> Q16_SHIFT);
      end
    end
  end

  // Wheel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel <= 2'd0;
    end else begin
      case (state)
        S_KO, S_SHRINK: wheel <= 2'd0;
        S_ROOT: begin
          if (root_done) begin
            wheel <= wheel + 2'd1;
          end
        end
        S_CHK: begin
          if (!over && wheel != 2'd3) begin
            wheel <= wheel + 2'd1;
          end
        end
        default: wheel <= wheel;
      endcase
    end
  end

  // Payload: command capture, rotation term, squares, magnitudes, speeds
  always_ff @(posedge clk) begin
    if (in_req) begin
      vx     <= s_axis_tdata[W-1:0];
      vy     <= s_axis_tdata[2*W-1:W];
      om     <= s_axis_tdata[3*W-1:2*W];
      enable <= s_axis_tuser[0];
      rev    <= s_axis_tuser[4:1];
    end
    if (state == S_KO) begin
      ko <= ko_calc;
    end
    if (state == S_SQB) begin
      sq_a <= RW'(prod);
    end
    if (state == S_ROOT && root_done) begin
      mag[wheel] <= root;
    end
    if (state == S_CHK) begin
      sc[wheel] <= SPEED_W'(chk);
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (out_req) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {spd[3], spd[2], spd[1], spd[0]};
    end
  end

endmodule

FILE: rtl/wsm_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on nothing but its parameters.
module wsm_mul #(
  parameter int AW = 17,
  parameter int BW = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  // Capture the product when a request is issued
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

FILE: rtl/wsm_isqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on nothing but its parameter RW (even radicand width).
module wsm_isqrt #(
  parameter int RW = 34
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RW-1:0]     radicand,
  output logic              done,
  output logic [RW/2-1:0]   root
);

  localparam int QW = RW / 2;
  localparam int CW = $clog2(QW);

  logic [RW-1:0]   xr;
  logic [QW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic            busy;

  logic [QW+3:0]   rem_sh;
  logic [QW+3:0]   trial;
  logic            take;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem, xr[RW-1:RW-2]};
    trial  = (QW+4)'({root, 2'b01});
    take   = rem_sh >= trial;
  end

  // Control: run QW steps after start, pulse done on the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, root and radicand shift
  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xr <= {xr[RW-3:0], 2'b00};
      if (take) begin
        rem  <= (QW+2)'(rem_sh - trial);
        root <= {root[QW-2:0], 1'b1};
      end else begin
        rem  <= (QW+2)'(rem_sh);
        root <= {root[QW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: bench/tb.sv
// Self-checking bench for wheel_speed_mixer_with_scaling: drives chassis command
// requests, predicts the four scaled wheel speeds and checks every result request.
// Depends on wsm_pkg and the RTL of the mixer.
module tb
  import wsm_pkg::*;
();

  // Predictor constants, Q0.16
  localparam longint HALF_ROOT2   = 46341;
  localparam longint SHRINK_STEP  = 64225;
  localparam int     FRAC_BITS    = 16;
  localparam int     DRAIN_GAP    = 150;
  localparam int     HOLD_CYCLES  = 1000;
  localparam int     CYCLE_LIMIT  = 2000000;
  localparam int     PHASE_ITEMS  = 370;

  typedef struct packed {
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] rot_rate;
    logic        drive_en;
    logic [3:0]  reverse;
  } cmd_t;

  // Wheel i sits at bits [16*i+15:16*i]
  typedef logic [3:0][SPEED_W-1:0] speeds_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_wen = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // from bit 0: vel_x, vel_y, rot_rate
  logic [47:0]         s_axis_tdata = '0;
  // from bit 0: drive_enable, reverse_0, reverse_1, reverse_2, reverse_3
  logic [4:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // from bit 0: speed_0, speed_1, speed_2, speed_3
  logic [63:0]         m_axis_tdata;

  // Predictor state
  longint unsigned     scale_q16 = 64'd1 << FRAC_BITS;
  longint unsigned     limit_now = 8191;
  speeds_t             pending_speeds[$];

  int                  tx_idle_pct  = 0;
  int                  rx_stall_pct = 0;
  bit                  hold_start   = 1'b0;
  bit                  rx_hold      = 1'b0;
  int                  hold_left    = 0;
  int                  error_count  = 0;
  int                  sent_count   = 0;
  int                  checked_count = 0;
  int                  cycle_count  = 0;

  wheel_speed_mixer_with_scaling i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count,
             pending_speeds.size());
    $display("wheel_speed_mixer_with_scaling test failed");
    $finish;
  end

  // Floor square root of a^2 + b^2
  function automatic longint unsigned wheel_mag(longint a, longint b);
    longint unsigned sq, root, trial;
    sq = a * a + b * b;
    root = 0;
    for (int bitpos = 17; bitpos >= 0; bitpos--) begin
      trial = root | (64'd1 << bitpos);
      if (trial * trial <= sq) root = trial;
    end
    return root;
  endfunction

  // Mix one command into wheel speeds; shrink the persistent scale as needed
  function automatic speeds_t mix_wheels(cmd_t c);
    longint vx, vy, ko;
    longint unsigned mag[4];
    longint unsigned lvl;
    bit over;
    speeds_t r;
    vx = longint'($signed(c.vel_x));
    vy = longint'($signed(c.vel_y));
    ko = (HALF_ROOT2 * longint'($signed(c.rot_rate))) >>> 16;
    mag[0] = wheel_mag(vy - ko, vx - ko);
    mag[1] = wheel_mag(vy + ko, vx - ko);
    mag[2] = wheel_mag(vy + ko, vx + ko);
    mag[3] = wheel_mag(vy - ko, vx + ko);
    do begin
      over = 1'b0;
      for (int w = 0; w < 4; w++)
        if (((mag[w] * scale_q16) >> FRAC_BITS) > limit_now) over = 1'b1;
      if (over) scale_q16 = (scale_q16 * SHRINK_STEP) >> 16;
    end while (over);
    for (int w = 0; w < 4; w++) begin
      lvl = c.drive_en ? ((mag[w] * scale_q16) >> FRAC_BITS) : 64'd0;
      if (c.reverse[w]) lvl = -lvl;
      r[w] = lvl[15:0];
    end
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [15:0] vx, logic [15:0] vy, logic [15:0] rot,
                                    logic en, logic [3:0] rev);
    cmd_t c;
    c.vel_x = vx;
    c.vel_y = vy;
    c.rot_rate = rot;
    c.drive_en = en;
    c.reverse = rev;
    return c;
  endfunction

  function automatic logic [15:0] edge_value();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'hffff;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'h7fff;
    endcase
  endfunction

  // Mix of full range, small, extreme, translation only and rotation only commands
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int kind;
    kind = $urandom_range(9);
    c.vel_x = 16'($urandom);
    c.vel_y = 16'($urandom);
    c.rot_rate = 16'($urandom);
    case (kind)
      5, 6: begin
        c.vel_x = 16'($urandom_range(1023)) - 16'd512;
        c.vel_y = 16'($urandom_range(1023)) - 16'd512;
        c.rot_rate = 16'($urandom_range(1023)) - 16'd512;
      end
      7: begin
        c.vel_x = edge_value();
        c.vel_y = edge_value();
        c.rot_rate = edge_value();
      end
      8: c.rot_rate = '0;
      9: begin
        c.vel_x = '0;
        c.vel_y = '0;
      end
      default: ;
    endcase
    c.drive_en = ($urandom_range(3) != 0);
    c.reverse = 4'($urandom);
    return c;
  endfunction

  task automatic report_mismatch(string what, int wheel, logic [15:0] got,
                                 logic [15:0] want);
    if (error_count < 50)
      $display("MISMATCH cycle %0d: %s wheel %0d got %h want %h", cycle_count, what,
               wheel, got, want);
    error_count++;
  endtask

  // Offer one command request and predict its result once accepted
  task automatic send_cmd(input cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c.rot_rate, c.vel_y, c.vel_x};
    s_axis_tuser <= {c.reverse, c.drive_en};
    do @(posedge clk); while (!s_axis_tready);
    pending_speeds.push_back(mix_wheels(c));
    sent_count++;
  endtask

  // Drop the request line and wait for every pending result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    drain_results();
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    limit_now = value;
  endtask

  // Count down a long receiver hold once one is requested
  initial begin : hold_timer
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_hold <= 1'b1;
      end else begin
        rx_hold <= 1'b0;
      end
    end
  end

  // Check each result request against the oldest prediction; drive tready
  initial begin : result_monitor
    speeds_t want, got;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_speeds.size() == 0) begin
          report_mismatch("result with nothing pending", 0, got[0], 16'h0);
        end else begin
          want = pending_speeds.pop_front();
          for (int w = 0; w < 4; w++)
            if (got[w] !== want[w]) report_mismatch("speed", w, got[w], want[w]);
          checked_count++;
        end
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Reset limit boundary, field extremes, drive off, reverse cases
  task automatic test_directed();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_cmd(make_cmd(16'd8191, 16'd0, 16'd0, 1'b1, 4'b0000));
    send_cmd(make_cmd(16'd8192, 16'd0, 16'd0, 1'b1, 4'b0000));
    set_limit(15'd32767);
    send_cmd(make_cmd(16'd0, 16'd0, 16'd0, 1'b1, 4'b0000));
    send_cmd(make_cmd(16'd32767, 16'd0, 16'd0, 1'b1, 4'b0000));
    send_cmd(make_cmd(16'h8000, 16'h8000, 16'd0, 1'b1, 4'b0000));
    send_cmd(make_cmd(16'd0, 16'd0, 16'h7fff, 1'b1, 4'b0000));
    send_cmd(make_cmd(16'd0, 16'd0, 16'h8000, 1'b1, 4'b0000));
    send_cmd(make_cmd(16'd0, 16'd0, 16'hffff, 1'b1, 4'b0000));
    send_cmd(make_cmd(16'd0, 16'd0, 16'h0001, 1'b1, 4'b0000));
    send_cmd(make_cmd(16'h8000, 16'h8000, 16'h7fff, 1'b1, 4'b1111));
    send_cmd(make_cmd(16'h7fff, 16'h7fff, 16'h8000, 1'b1, 4'b0101));
    // drive off still shrinks the scale
    send_cmd(make_cmd(16'h8000, 16'h7fff, 16'h8000, 1'b0, 4'b1010));
    // reverse with zero speed stays zero
    send_cmd(make_cmd(16'd0, 16'd0, 16'd0, 1'b1, 4'b1111));
    send_cmd(make_cmd(16'd1000, 16'hfc18, 16'd300, 1'b1, 4'b0110));
    send_cmd(make_cmd(16'hffff, 16'h0001, 16'hffff, 1'b1, 4'b1001));
    send_cmd(make_cmd(16'd12345, 16'd23456, 16'hd000, 1'b0, 4'b0000));
  endtask

  task automatic test_random(input int n_items, input int tx_pct, input int rx_pct,
                             input logic [LIMIT_W-1:0] limit);
    set_limit(limit);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n_items) send_cmd(rand_cmd());
  endtask

  // Hold off results for a long stretch so the input stalls
  task automatic test_backpressure();
    drain_results();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_start = 1'b1;
    repeat (30) send_cmd(rand_cmd());
  endtask

  // Smallest limits: with zero the scale runs down to nothing
  task automatic test_min_limits();
    test_random(8, 27, 27, 15'd1);
    set_limit(15'd0);
    send_cmd(make_cmd(16'h8000, 16'h8000, 16'h7fff, 1'b1, 4'b0011));
    repeat (8) send_cmd(rand_cmd());
    send_cmd(make_cmd(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 4'b1111));
  endtask

  initial begin : run_tests
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(PHASE_ITEMS, 0, 0, 15'd32767);
    test_random(PHASE_ITEMS, 54, 0, 15'd20000);
    test_random(PHASE_ITEMS, 0, 54, LIMIT_W'($urandom_range(32767, 1)));
    test_random(PHASE_ITEMS, 27, 27, 15'd4000);
    test_backpressure();
    test_min_limits();
    drain_results();
    $display("covered %0d commands and %0d checked results over limits from 32767 to 0",
             sent_count, checked_count);
    $display("predicted scale at the end %0d, mismatches %0d", scale_q16, error_count);
    if (error_count == 0) begin
      $display("wheel_speed_mixer_with_scaling test passed");
    end else begin
      $display("wheel_speed_mixer_with_scaling test failed");
    end
    $finish;
  end

endmodule

FILE: wheel_speed_mixer_with_scaling.f
rtl/wsm_pkg.sv
rtl/wsm_mul.sv
rtl/wsm_isqrt.sv
rtl/wheel_speed_mixer_with_scaling.sv
bench/tb.sv
